// File: hdl/jtl_pkg.sv
// jtl_pkg: types, token codes and character helpers for the json token lexer
// used by every module of the lexer; depends on nothing else

package jtl_pkg;

  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 20;
  localparam int BUNDLE_TOKS = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             token_kind;
    logic [1:0]             event_phase;
    logic [7:0]             value_byte;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    logic [1:0]             error_code;
    logic                   run_last;
  } tok_t;

  // up to three results of one request, oldest in toks[0]
  typedef struct packed {
    tok_t [BUNDLE_TOKS-1:0] toks;
    logic [1:0]             num;
  } bundle_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_NUM,
    MODE_KW,
    MODE_HALT
  } lex_mode_e;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_STRING   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_TRUE     = 4'd8;
  localparam logic [3:0] KIND_EOF      = 4'd11;
  localparam logic [3:0] KIND_INVALID  = 4'd12;

  localparam logic [1:0] PHASE_WHOLE = 2'd0;
  localparam logic [1:0] PHASE_VALUE = 2'd1;
  localparam logic [1:0] PHASE_END   = 2'd2;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_BAD_START    = 2'd1;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd2;
  localparam logic [1:0] ERR_BAD_KEYWORD  = 2'd3;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [2:0] KW_INDEX_MAX = 3'd5;

  function automatic logic [1:0] kw_clamp(logic [1:0] c);
    kw_clamp = (c > KW_NULL) ? KW_NULL : c;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] c);
    kw_len = (kw_clamp(c) == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // spelling of true, false and null
  function automatic logic [7:0] kw_char(logic [1:0] c, logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kw_clamp(c))
      KW_TRUE: begin
        case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    kw_char = ch;
  endfunction

  function automatic logic kw_miss(logic [1:0] c, logic [2:0] idx, logic [7:0] b);
    kw_miss = !((idx < kw_len(c)) && (b == kw_char(c, idx)));
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      "b":     r = 8'd8;
      "f":     r = 8'd12;
      "n":     r = 8'd10;
      "r":     r = 8'd13;
      "t":     r = 8'd9;
      default: r = b;
    endcase
    unescape = r;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_numchar(logic [7:0] b);
    is_numchar = is_digit(b) || (b == ".") || (b == "e") || (b == "E") ||
                 (b == "+") || (b == "-");
  endfunction

  function automatic tok_t make_tok(logic [3:0] kind, logic [1:0] phase,
                                    logic [7:0] val, logic [LINE_BITS-1:0] ln,
                                    logic [COLUMN_BITS-1:0] col, logic [1:0] err);
    tok_t t;
    t.token_kind   = kind;
    t.event_phase  = phase;
    t.value_byte   = val;
    t.token_line   = ln;
    t.token_column = col;
    t.error_code   = err;
    t.run_last     = 1'b0;
    make_tok = t;
  endfunction

endpackage

// File: hdl/jtl_front.sv
// jtl_front: lexer state, position tracking and per-request result bundle
// depends on jtl_pkg

module jtl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jtl_pkg::in_item_t in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output jtl_pkg::bundle_t  bundle_o
);

  jtl_pkg::lex_mode_e                  mode_q, mode_d;
  logic [jtl_pkg::LINE_BITS-1:0]       line_q, line_d;
  logic [jtl_pkg::COLUMN_BITS-1:0]     col_q, col_d;
  logic [jtl_pkg::LINE_BITS-1:0]       sline_q, sline_d;
  logic [jtl_pkg::COLUMN_BITS-1:0]     scol_q, scol_d;
  logic [1:0]                          kcand_q, kcand_d;
  logic [2:0]                          kidx_q, kidx_d;
  logic                                kmiss_q, kmiss_d;

  jtl_pkg::tok_t                       slot [4];
  logic [2:0]                          cnt;
  logic                                accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // one lexer step: state update and the ordered list of results
  always_comb begin
    logic [7:0] b;
    logic       run_idle;
    logic [3:0] punct;
    logic       is_punct;
    b        = in_i.data_byte;
    run_idle = 1'b0;
    punct    = jtl_pkg::KIND_LBRACE;
    is_punct = 1'b0;
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    kcand_d  = kcand_q;
    kidx_d   = kidx_q;
    kmiss_d  = kmiss_q;
    cnt      = 3'd0;
    for (int i = 0; i < 4; i++) begin
      slot[i] = '0;
    end

    if (in_i.has_byte) begin
      unique case (mode_q)
        jtl_pkg::MODE_HALT: begin
        end
        jtl_pkg::MODE_STR: begin
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          if (b == "\"") begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_STRING, jtl_pkg::PHASE_END,
                                               8'h00, sline_d, scol_d, jtl_pkg::ERR_NONE);
            cnt    = cnt + 3'd1;
            mode_d = jtl_pkg::MODE_IDLE;
          end else if (b == "\\") begin
            mode_d = jtl_pkg::MODE_ESC;
          end else begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_STRING, jtl_pkg::PHASE_VALUE,
                                               b, sline_d, scol_d, jtl_pkg::ERR_NONE);
            cnt = cnt + 3'd1;
          end
        end
        jtl_pkg::MODE_ESC: begin
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_STRING, jtl_pkg::PHASE_VALUE,
                                             jtl_pkg::unescape(b), sline_d, scol_d,
                                             jtl_pkg::ERR_NONE);
          cnt    = cnt + 3'd1;
          mode_d = jtl_pkg::MODE_STR;
        end
        jtl_pkg::MODE_NUM: begin
          if (jtl_pkg::is_numchar(b)) begin
            if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::PHASE_VALUE,
                                               b, sline_d, scol_d, jtl_pkg::ERR_NONE);
            cnt = cnt + 3'd1;
          end else begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::PHASE_END,
                                               8'h00, sline_d, scol_d, jtl_pkg::ERR_NONE);
            cnt      = cnt + 3'd1;
            mode_d   = jtl_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        jtl_pkg::MODE_KW: begin
          if (jtl_pkg::is_alpha(b)) begin
            if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
            if (jtl_pkg::kw_miss(kcand_d, kidx_d, b)) kmiss_d = 1'b1;
            if (kidx_d < jtl_pkg::KW_INDEX_MAX) kidx_d = kidx_d + 3'd1;
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_TRUE +
                                               {2'b00, jtl_pkg::kw_clamp(kcand_d)},
                                               jtl_pkg::PHASE_VALUE, b, sline_d, scol_d,
                                               jtl_pkg::ERR_NONE);
            cnt = cnt + 3'd1;
          end else if (kmiss_d || (kidx_d != jtl_pkg::kw_len(kcand_d))) begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_INVALID, jtl_pkg::PHASE_WHOLE,
                                               8'h00, sline_d, scol_d,
                                               jtl_pkg::ERR_BAD_KEYWORD);
            cnt    = cnt + 3'd1;
            mode_d = jtl_pkg::MODE_HALT;
          end else begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_TRUE +
                                               {2'b00, jtl_pkg::kw_clamp(kcand_d)},
                                               jtl_pkg::PHASE_END, 8'h00, sline_d, scol_d,
                                               jtl_pkg::ERR_NONE);
            cnt      = cnt + 3'd1;
            mode_d   = jtl_pkg::MODE_IDLE;
            run_idle = 1'b1;
          end
        end
        default: begin
          mode_d   = jtl_pkg::MODE_IDLE;
          run_idle = 1'b1;
        end
      endcase

      // a byte seen in idle mode, and the byte that ended a number or a complete keyword, are lexed from idle
      if (run_idle) begin
        unique case (b)
          "{": begin punct = jtl_pkg::KIND_LBRACE;   is_punct = 1'b1; end
          "}": begin punct = jtl_pkg::KIND_RBRACE;   is_punct = 1'b1; end
          "[": begin punct = jtl_pkg::KIND_LBRACKET; is_punct = 1'b1; end
          "]": begin punct = jtl_pkg::KIND_RBRACKET; is_punct = 1'b1; end
          ":": begin punct = jtl_pkg::KIND_COLON;    is_punct = 1'b1; end
          ",": begin punct = jtl_pkg::KIND_COMMA;    is_punct = 1'b1; end
          default: begin
            punct    = jtl_pkg::KIND_LBRACE;
            is_punct = 1'b0;
          end
        endcase

        if ((b == " ") || (b == 8'd9) || (b == 8'd13)) begin
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
        end else if (b == 8'd10) begin
          col_d = jtl_pkg::COLUMN_BITS'(1);
          if (line_d != '1) line_d = line_d + jtl_pkg::LINE_BITS'(1);
        end else if (is_punct) begin
          sline_d = line_d;
          scol_d  = col_d;
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          slot[cnt[1:0]] = jtl_pkg::make_tok(punct, jtl_pkg::PHASE_WHOLE, 8'h00,
                                             sline_d, scol_d, jtl_pkg::ERR_NONE);
          cnt = cnt + 3'd1;
        end else if (b == "\"") begin
          sline_d = line_d;
          scol_d  = col_d;
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          mode_d = jtl_pkg::MODE_STR;
        end else if ((b == "-") || jtl_pkg::is_digit(b)) begin
          sline_d = line_d;
          scol_d  = col_d;
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::PHASE_VALUE,
                                             b, sline_d, scol_d, jtl_pkg::ERR_NONE);
          cnt    = cnt + 3'd1;
          mode_d = jtl_pkg::MODE_NUM;
        end else if ((b == "t") || (b == "f") || (b == "n")) begin
          sline_d = line_d;
          scol_d  = col_d;
          kcand_d = (b == "t") ? jtl_pkg::KW_TRUE :
                    (b == "f") ? jtl_pkg::KW_FALSE : jtl_pkg::KW_NULL;
          if (col_d != '1) col_d = col_d + jtl_pkg::COLUMN_BITS'(1);
          // first letter always matches its own candidate
          kidx_d  = 3'd1;
          kmiss_d = 1'b0;
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_TRUE + {2'b00, kcand_d},
                                             jtl_pkg::PHASE_VALUE, b, sline_d, scol_d,
                                             jtl_pkg::ERR_NONE);
          cnt    = cnt + 3'd1;
          mode_d = jtl_pkg::MODE_KW;
        end else begin
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_INVALID, jtl_pkg::PHASE_WHOLE,
                                             8'h00, line_d, col_d,
                                             jtl_pkg::ERR_BAD_START);
          cnt    = cnt + 3'd1;
          mode_d = jtl_pkg::MODE_HALT;
        end
      end
    end

    if (in_i.end_of_input) begin
      unique case (mode_d) inside
        jtl_pkg::MODE_HALT: begin
        end
        jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC: begin
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_INVALID, jtl_pkg::PHASE_WHOLE,
                                             8'h00, sline_d, scol_d,
                                             jtl_pkg::ERR_UNTERMINATED);
          cnt = cnt + 3'd1;
        end
        jtl_pkg::MODE_NUM: begin
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::PHASE_END,
                                             8'h00, sline_d, scol_d, jtl_pkg::ERR_NONE);
          cnt = cnt + 3'd1;
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_EOF, jtl_pkg::PHASE_WHOLE,
                                             8'h00, line_d, col_d, jtl_pkg::ERR_NONE);
          cnt = cnt + 3'd1;
        end
        jtl_pkg::MODE_KW: begin
          if (!kmiss_d && (kidx_d == jtl_pkg::kw_len(kcand_d))) begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_TRUE +
                                               {2'b00, jtl_pkg::kw_clamp(kcand_d)},
                                               jtl_pkg::PHASE_END, 8'h00, sline_d, scol_d,
                                               jtl_pkg::ERR_NONE);
            cnt = cnt + 3'd1;
            if (cnt < 3'd4) begin
              slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_EOF, jtl_pkg::PHASE_WHOLE,
                                                 8'h00, line_d, col_d, jtl_pkg::ERR_NONE);
              cnt = cnt + 3'd1;
            end
          end else begin
            slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_INVALID, jtl_pkg::PHASE_WHOLE,
                                               8'h00, sline_d, scol_d,
                                               jtl_pkg::ERR_BAD_KEYWORD);
            cnt = cnt + 3'd1;
          end
        end
        default: begin
          slot[cnt[1:0]] = jtl_pkg::make_tok(jtl_pkg::KIND_EOF, jtl_pkg::PHASE_WHOLE,
                                             8'h00, line_d, col_d, jtl_pkg::ERR_NONE);
          cnt = cnt + 3'd1;
        end
      endcase
      // next document starts from reset state
      mode_d  = jtl_pkg::MODE_IDLE;
      line_d  = jtl_pkg::LINE_BITS'(1);
      col_d   = jtl_pkg::COLUMN_BITS'(1);
      sline_d = jtl_pkg::LINE_BITS'(1);
      scol_d  = jtl_pkg::COLUMN_BITS'(1);
      kcand_d = jtl_pkg::KW_TRUE;
      kidx_d  = 3'd0;
      kmiss_d = 1'b0;
    end
  end

  // pack at most three results and flag the last one
  always_comb begin
    logic [1:0] n;
    n = (cnt > 3'd3) ? 2'd3 : cnt[1:0];
    bundle_o.num = n;
    for (int i = 0; i < jtl_pkg::BUNDLE_TOKS; i++) begin
      bundle_o.toks[i]          = slot[i];
      bundle_o.toks[i].run_last = (2'(i) == (n - 2'd1));
    end
    push_o = accept && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtl_pkg::MODE_IDLE;
      line_q  <= jtl_pkg::LINE_BITS'(1);
      col_q   <= jtl_pkg::COLUMN_BITS'(1);
      sline_q <= jtl_pkg::LINE_BITS'(1);
      scol_q  <= jtl_pkg::COLUMN_BITS'(1);
      kcand_q <= jtl_pkg::KW_TRUE;
      kidx_q  <= 3'd0;
      kmiss_q <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      kcand_q <= kcand_d;
      kidx_q  <= kidx_d;
      kmiss_q <= kmiss_d;
    end
  end

endmodule

// File: hdl/jtl_queue.sv
// jtl_queue: short bundle queue between the lexer front and the result back end
// depends on jtl_pkg

module jtl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jtl_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output jtl_pkg::bundle_t pop_data_o
);

  localparam int PtrBits = $clog2(jtl_pkg::QUEUE_DEPTH);

  jtl_pkg::bundle_t   mem_q [jtl_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == (PtrBits + 1)'(jtl_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(jtl_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(jtl_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + PtrBits'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (PtrBits + 1)'(1);
      2'b01:   count_d = count_q - (PtrBits + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hdl/jtl_back.sv
// jtl_back: holds one bundle and hands its results out one per cycle while out_ready_i is high
// depends on jtl_pkg

module jtl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  jtl_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jtl_pkg::tok_t    out_o
);

  jtl_pkg::bundle_t cur_q, cur_d;
  logic             busy_q, busy_d;
  logic [1:0]       idx_q, idx_d;
  logic             fire, last, take;

  assign out_valid_o = busy_q;
  assign out_o       = cur_q.toks[idx_q];
  assign fire        = busy_q && out_ready_i;
  assign last        = (idx_q == (cur_q.num - 2'd1));
  // load the next bundle when idle or as the last result of this one leaves
  assign take        = !busy_q || (fire && last);
  assign q_pop_o     = take && q_valid_i;

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take) begin
      busy_d = q_valid_i;
      cur_d  = q_data_i;
      idx_d  = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// File: hdl/json_token_lexer_unit.sv
// json_token_lexer_unit: top level of the json token lexer
// depends on jtl_pkg, jtl_front, jtl_queue and jtl_back
//
//   channel   signals                            carries
//   input     in_valid_i  in_ready_o  in_i       one document byte and end flag
//   output    out_valid_o out_ready_i out_o      one token event
//
// one request a cycle is taken while the bundle queue has room; the front lexes
// it in the same cycle and queues up to three of its results as one entry
// the back end emits one result a cycle from its output register while out_ready_i is
// high, so requests that cause two or three results can fill the two-entry queue and hold off input
// reset clears the lexer state, the queue and the output stage; no clearing pass
// a stalled output only stalls input once the queue is full

module json_token_lexer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jtl_pkg::in_item_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jtl_pkg::tok_t     out_o
);

  logic             push, q_full, q_valid, q_pop;
  jtl_pkg::bundle_t push_data, q_data;

  jtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  jtl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  jtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
